>>> hdl/wis_pkg.sv
`default_nettype none

package wis_pkg;

    // default sizing of the table
    localparam int ENTRIES_DEFAULT      = 64;
    localparam int WEIGHT_BITS_DEFAULT  = 16;
    localparam int UNIFORM_BITS_DEFAULT = 32;

    // fixed port widths
    localparam int COMMAND_BITS      = 2;
    localparam int INDEX_BITS        = 6;
    localparam int WEIGHT_PORT_BITS  = 16;
    localparam int UNIFORM_PORT_BITS = 32;

    // command codes
    localparam logic [COMMAND_BITS-1:0] CMD_LOAD    = 2'd0;
    localparam logic [COMMAND_BITS-1:0] CMD_DRAW    = 2'd1;
    localparam logic [COMMAND_BITS-1:0] CMD_RESTART = 2'd2;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic
    {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } wis_alu_op_t;

    // write controls of the weight and taken stores
    typedef struct packed
    {
        logic weight_we;
        logic taken_we;
        logic taken_wdata;
    } wis_store_ctl_t;

endpackage

`default_nettype wire

>>> hdl/weighted_index_sampler_top.sv
`default_nettype none

// roulette-wheel sampler over a table of ENTRIES weights. one item is taken
// when start is high and busy is low; a draw item gives exactly one result,
// shown for a single cycle with done high, and the receiver cannot stall it,
// so it must take the result in that cycle. load and restart items give no
// result. after reset the block clears both tables (busy high). a restart
// clears the taken marks; a load first replaces the weight in the total and
// the table, then clears the taken marks too. a draw runs the bit-serial
// scaling of the remaining total, then the table walk up to the chosen
// entry, then removes that entry when drawing without replacement; the walk
// reads one table entry per cycle from the weight memory, and every step
// goes through one shared adder. a draw on an empty pool answers in the
// cycle after it is taken, with status set.
module weighted_index_sampler_top
    import wis_pkg::*;
#(
    parameter int ENTRIES      = ENTRIES_DEFAULT,
    parameter int WEIGHT_BITS  = WEIGHT_BITS_DEFAULT,
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEFAULT
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // item channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [COMMAND_BITS-1:0]      command,
    input  wire logic [INDEX_BITS-1:0]        entry_index,
    input  wire logic [WEIGHT_PORT_BITS-1:0]  weight,
    input  wire logic [UNIFORM_PORT_BITS-1:0] uniform,
    // mode register
    input  wire logic                         cfg_write_en,
    input  wire logic                         cfg_write_data,
    // result channel
    output logic                              done,
    output logic [INDEX_BITS-1:0]             chosen_index,
    output logic                              status
);

    localparam int IDX_W   = $clog2(ENTRIES);
    // totals are exact sums of all weights
    localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
    localparam int CNT_E   = $clog2(ENTRIES + 1);
    localparam int CNT_U   = $clog2(UNIFORM_BITS + 1);
    localparam int CNT_W   = (CNT_E > CNT_U) ? CNT_E : CNT_U;

    typedef enum logic [7:0]
    {
        ST_CLEAR    = 8'b0000_0001,  // clear both tables after reset
        ST_IDLE     = 8'b0000_0010,
        ST_LOAD_SUB = 8'b0000_0100,  // full total minus old weight
        ST_LOAD_ADD = 8'b0000_1000,  // plus new weight, write table
        ST_SWEEP    = 8'b0001_0000,  // clear taken marks
        ST_MUL      = 8'b0010_0000,  // shift-add scaling of the total
        ST_WALK     = 8'b0100_0000,  // running sum over the table
        ST_TAKE     = 8'b1000_0000   // remove the drawn entry
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_W-1:0] full_reg, full_next;
    logic [TOTAL_W-1:0] remaining_reg, remaining_next;
    logic               without_replacement_reg, without_replacement_next;
    logic               done_reg, done_next;

    // item payload and work registers
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [WEIGHT_BITS-1:0]  w_reg, w_next;
    logic [UNIFORM_BITS-1:0] u_reg, u_next;
    logic [TOTAL_W-1:0]      prod_reg, prod_next;   // becomes the target
    logic [TOTAL_W-1:0]      sum_reg, sum_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic [WEIGHT_BITS-1:0]  hit_w_reg, hit_w_next;
    logic [INDEX_BITS-1:0]   chosen_reg, chosen_next;
    logic                    status_reg, status_next;

    // shared adder
    wis_alu_op_t        alu_op;
    logic [TOTAL_W-1:0] alu_a;
    logic [TOTAL_W-1:0] alu_b;
    logic [TOTAL_W:0]   alu_y;

    // table access
    wis_store_ctl_t         store_ctl;
    logic [IDX_W-1:0]       wr_addr;
    logic [WEIGHT_BITS-1:0] wr_weight;
    logic [IDX_W-1:0]       rd_addr;
    logic [WEIGHT_BITS-1:0] rd_weight;
    logic                   rd_taken;

    // port fields brought to the configured widths
    logic [31:0]             idx_wide;
    logic [IDX_W-1:0]        idx_port;
    logic                    idx_in_range;
    logic [63:0]             w_wide;
    logic [63:0]             u_wide;
    logic [CNT_W-1:0]        cnt_inc;
    logic [31:0]             cnt_wide;
    logic                    accept;
    logic                    walk_hit;
    logic                    cnt_last_entry;
    logic                    cnt_last_bit;

    assign idx_wide     = 32'(entry_index);
    assign idx_port     = idx_wide[IDX_W-1:0];
    assign idx_in_range = (idx_wide < 32'(ENTRIES));
    assign w_wide       = 64'(weight);
    assign u_wide       = 64'(uniform);
    assign cnt_inc      = cnt_reg + CNT_W'(1);
    assign cnt_wide     = 32'(cnt_reg);

    assign accept         = start && (state_reg == ST_IDLE);
    assign cnt_last_entry = (cnt_reg == CNT_W'(ENTRIES - 1));
    assign cnt_last_bit   = (cnt_reg == CNT_W'(UNIFORM_BITS - 1));

    // half-open intervals: the first untaken entry whose running sum passes
    // the target; zero weights never pass since the sum does not move
    assign walk_hit = !rd_taken && ({1'b0, prod_reg} < alu_y);

    wis_alu #(
        .W (TOTAL_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    wis_store #(
        .ENTRIES     (ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_store (
        .clk       (clk),
        .ctl       (store_ctl),
        .wr_addr   (wr_addr),
        .wr_weight (wr_weight),
        .rd_addr   (rd_addr),
        .rd_weight (rd_weight),
        .rd_taken  (rd_taken)
    );

    // operand selection for the shared adder
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = sum_reg;
        alu_b  = '0;
        unique case (state_reg)
            ST_MUL:
            begin
                alu_a = prod_reg;
                alu_b = u_reg[0] ? remaining_reg : '0;
            end
            ST_LOAD_SUB:
            begin
                alu_op = ALU_SUB;
                alu_a  = full_reg;
                alu_b  = TOTAL_W'(rd_weight);
            end
            ST_LOAD_ADD:
            begin
                alu_a = full_reg;
                alu_b = TOTAL_W'(w_reg);
            end
            ST_WALK:
            begin
                alu_a = sum_reg;
                alu_b = rd_taken ? '0 : TOTAL_W'(rd_weight);
            end
            ST_TAKE:
            begin
                alu_op = ALU_SUB;
                alu_a  = remaining_reg;
                alu_b  = TOTAL_W'(hit_w_reg);
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next               = state_reg;
        cnt_next                 = cnt_reg;
        full_next                = full_reg;
        remaining_next           = remaining_reg;
        without_replacement_next = cfg_write_en ? cfg_write_data : without_replacement_reg;
        done_next                = 1'b0;

        idx_next     = idx_reg;
        w_next       = w_reg;
        u_next       = u_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        hit_idx_next = hit_idx_reg;
        hit_w_next   = hit_w_reg;
        chosen_next  = chosen_reg;
        status_next  = status_reg;

        store_ctl = '0;
        wr_addr   = cnt_reg[IDX_W-1:0];
        wr_weight = '0;
        rd_addr   = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                store_ctl.weight_we = 1'b1;
                store_ctl.taken_we  = 1'b1;
                cnt_next            = cnt_inc;
                if (cnt_last_entry)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                // old weight read ahead of a load
                rd_addr = idx_port;
                if (accept)
                begin
                    idx_next = idx_port;
                    w_next   = w_wide[WEIGHT_BITS-1:0];
                    cnt_next = '0;
                    case (command)
                        CMD_LOAD:
                        begin
                            // an index beyond the table only restarts
                            state_next = idx_in_range ? ST_LOAD_SUB : ST_SWEEP;
                        end
                        CMD_RESTART:
                        begin
                            state_next = ST_SWEEP;
                        end
                        CMD_DRAW:
                        begin
                            if (remaining_reg == '0)
                            begin
                                done_next   = 1'b1;
                                chosen_next = '0;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                u_next     = u_wide[UNIFORM_BITS-1:0];
                                prod_next  = '0;
                                sum_next   = '0;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_LOAD_SUB:
            begin
                full_next  = alu_y[TOTAL_W-1:0];
                state_next = ST_LOAD_ADD;
            end

            ST_LOAD_ADD:
            begin
                full_next           = alu_y[TOTAL_W-1:0];
                store_ctl.weight_we = 1'b1;
                wr_addr             = idx_reg;
                wr_weight           = w_reg;
                state_next          = ST_SWEEP;
            end

            ST_SWEEP:
            begin
                store_ctl.taken_we = 1'b1;
                cnt_next           = cnt_inc;
                if (cnt_last_entry)
                begin
                    cnt_next       = '0;
                    remaining_next = full_reg;
                    state_next     = ST_IDLE;
                end
            end

            ST_MUL:
            begin
                // one multiplier bit per cycle, low bits shift out
                rd_addr   = '0;
                prod_next = alu_y[TOTAL_W:1];
                u_next    = u_reg >> 1;
                cnt_next  = cnt_inc;
                if (cnt_last_bit)
                begin
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                // data for entry cnt is here, fetch the next one
                rd_addr      = cnt_inc[IDX_W-1:0];
                sum_next     = alu_y[TOTAL_W-1:0];
                cnt_next     = cnt_inc;
                hit_idx_next = cnt_reg[IDX_W-1:0];
                hit_w_next   = rd_weight;
                if (walk_hit)
                begin
                    chosen_next = cnt_wide[INDEX_BITS-1:0];
                    status_next = STATUS_OK;
                    if (without_replacement_reg)
                    begin
                        state_next = ST_TAKE;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (cnt_last_entry)
                begin
                    // no entry passed the target
                    done_next   = 1'b1;
                    chosen_next = '0;
                    status_next = STATUS_EMPTY;
                    state_next  = ST_IDLE;
                end
            end

            ST_TAKE:
            begin
                remaining_next        = alu_y[TOTAL_W-1:0];
                store_ctl.taken_we    = 1'b1;
                store_ctl.taken_wdata = 1'b1;
                wr_addr               = hit_idx_reg;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg               <= ST_CLEAR;
            cnt_reg                 <= '0;
            full_reg                <= '0;
            remaining_reg           <= '0;
            without_replacement_reg <= 1'b0;
            done_reg                <= 1'b0;
        end
        else
        begin
            state_reg               <= state_next;
            cnt_reg                 <= cnt_next;
            full_reg                <= full_next;
            remaining_reg           <= remaining_next;
            without_replacement_reg <= without_replacement_next;
            done_reg                <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        w_reg       <= w_next;
        u_reg       <= u_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        hit_idx_reg <= hit_idx_next;
        hit_w_reg   <= hit_w_next;
        chosen_reg  <= chosen_next;
        status_reg  <= status_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign chosen_index = chosen_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

>>> hdl/wis_alu.sv
`default_nettype none

module wis_alu
    import wis_pkg::*;
#(
    parameter int W = 22
)
(
    input  wire wis_alu_op_t op,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic      [W:0]   y
);

    // one carry bit on top for add, borrow for sub
    always_comb
    begin
        unique case (op)
            ALU_ADD: y = {1'b0, a} + {1'b0, b};
            ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default: y = {1'b0, a};
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/wis_store.sv
`default_nettype none

module wis_store
    import wis_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEFAULT,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
    localparam int IDX_W      = $clog2(ENTRIES)
)
(
    input  wire logic                   clk,
    input  wire wis_store_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]       wr_addr,
    input  wire logic [WEIGHT_BITS-1:0] wr_weight,
    input  wire logic [IDX_W-1:0]       rd_addr,
    output logic      [WEIGHT_BITS-1:0] rd_weight,
    output logic                        rd_taken
);

    logic [WEIGHT_BITS-1:0] weight_mem [ENTRIES];
    logic                   taken_mem  [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.weight_we)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        rd_weight <= weight_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.taken_we)
        begin
            taken_mem[wr_addr] <= ctl.taken_wdata;
        end
        rd_taken <= taken_mem[rd_addr];
    end

endmodule

`default_nettype wire
